[sv/ptrs_pkg.sv]
// ----------------------------------------------------------------------------
// Power timer register slave package
// Shared types, register addresses and the read group lookup.
// ----------------------------------------------------------------------------
package ptrs_pkg;

    // Bus command codes carried in the input tuser
    localparam logic [1:0] CMD_POINTER = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Register addresses
    localparam logic [7:0] ADDR_POWER_HOLD = 8'h00;
    localparam logic [7:0] ADDR_BACKLIGHT  = 8'h01;
    localparam logic [7:0] ADDR_BUTTON_A   = 8'h10;
    localparam logic [7:0] ADDR_BUTTON_B   = 8'h11;
    localparam logic [7:0] ADDR_WAKE_SRC   = 8'h20;
    localparam logic [7:0] ADDR_SLEEP_SRC  = 8'h21;
    localparam logic [7:0] ADDR_WAKE_TIME  = 8'h30;
    localparam logic [7:0] ADDR_WAKE_END   = 8'h32;
    localparam logic [7:0] ADDR_SLEEP_REQ  = 8'h40;
    localparam logic [7:0] ADDR_CYCLE_MODE = 8'h41;
    localparam logic [7:0] ADDR_MEAS_LO    = 8'h60;
    localparam logic [7:0] ADDR_MEAS_HI    = 8'h77;
    localparam logic [7:0] ADDR_SLEEP_TIME = 8'h80;
    localparam logic [7:0] ADDR_SLEEP_END  = 8'h82;
    localparam logic [7:0] ADDR_CHARGING   = 8'h90;
    localparam logic [7:0] ADDR_BOOT_SEL   = 8'hF1;
    localparam logic [7:0] ADDR_FW_ID      = 8'hFE;
    localparam logic [7:0] ADDR_SLAVE_ADDR = 8'hFF;

    localparam logic [2:0] SOURCE_MASK    = 3'h7;
    localparam int         NUM_MEAS_WORDS = 6;

    // Parameter defaults
    localparam int DEFAULT_ADDRESS_DEF = 86;
    localparam int FIRMWARE_ID_DEF     = 1;
    localparam int BUS_SLEEP_BIT_DEF   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply_pointer;
        logic apply_write;
        logic start_read;
        logic load_byte;
        logic advance;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       read_mapped;
        logic       run_done;
    } t_ctrl_status;

    typedef struct packed {
        logic       mapped;
        logic [7:0] last_addr;
    } t_group;

    // Read group of a pointer: whether it is readable and the group's last address
    function automatic t_group read_group(input logic [7:0] ptr);
        t_group g;
        g.mapped    = 1'b1;
        g.last_addr = ptr;
        if (ptr == ADDR_BUTTON_A || ptr == ADDR_BUTTON_B) begin
            g.last_addr = ADDR_BUTTON_B;
        end else if (ptr == ADDR_WAKE_SRC || ptr == ADDR_SLEEP_SRC) begin
            g.last_addr = ADDR_SLEEP_SRC;
        end else if (ptr >= ADDR_WAKE_TIME && ptr <= ADDR_WAKE_END) begin
            g.last_addr = ADDR_WAKE_END;
        end else if (ptr >= ADDR_SLEEP_TIME && ptr <= ADDR_SLEEP_END) begin
            g.last_addr = ADDR_SLEEP_END;
        end else if (ptr >= ADDR_MEAS_LO && ptr <= ADDR_MEAS_HI) begin
            g.last_addr = ADDR_MEAS_HI;
        end else if (ptr == ADDR_POWER_HOLD || ptr == ADDR_BACKLIGHT
                     || ptr == ADDR_CYCLE_MODE || ptr == ADDR_CHARGING
                     || ptr == ADDR_FW_ID || ptr == ADDR_BOOT_SEL
                     || ptr == ADDR_SLAVE_ADDR) begin
            g.last_addr = ptr;
        end else begin
            g.mapped = 1'b0;
        end
        return g;
    endfunction

endpackage

[sv/ptrs_ctrl.sv]
// ----------------------------------------------------------------------------
// Power timer register slave controller
// Sequences capture, decode, byte load and send for one bus item at a time.
// ----------------------------------------------------------------------------
module ptrs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    input  ptrs_pkg::t_ctrl_status i_status,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output ptrs_pkg::t_ctrl_cmd   o_cmd
);

    ptrs_pkg::t_state r_state;
    ptrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptrs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ptrs_pkg::ST_DECODE;
                end
            end
            ptrs_pkg::ST_DECODE: begin
                if (i_status.cmd == ptrs_pkg::CMD_WRITE) begin
                    n_state = ptrs_pkg::ST_SEND;
                end else if (i_status.cmd == ptrs_pkg::CMD_READ && i_status.read_mapped) begin
                    n_state = ptrs_pkg::ST_LOAD;
                end else begin
                    n_state = ptrs_pkg::ST_IDLE;
                end
            end
            ptrs_pkg::ST_LOAD: begin
                n_state = ptrs_pkg::ST_SEND;
            end
            ptrs_pkg::ST_SEND: begin
                if (i_out_ready) begin
                    n_state = i_status.run_done ? ptrs_pkg::ST_IDLE : ptrs_pkg::ST_LOAD;
                end
            end
            default: n_state = ptrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ptrs_pkg::ST_IDLE);
        o_out_valid = (r_state == ptrs_pkg::ST_SEND);
        o_cmd       = '0;
        unique case (r_state)
            ptrs_pkg::ST_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            ptrs_pkg::ST_DECODE: begin
                o_cmd.apply_pointer = (i_status.cmd == ptrs_pkg::CMD_POINTER);
                o_cmd.apply_write   = (i_status.cmd == ptrs_pkg::CMD_WRITE);
                o_cmd.start_read    = (i_status.cmd == ptrs_pkg::CMD_READ)
                                      && i_status.read_mapped;
            end
            ptrs_pkg::ST_LOAD: begin
                o_cmd.load_byte = 1'b1;
            end
            ptrs_pkg::ST_SEND: begin
                o_cmd.advance = i_out_ready && !i_status.run_done;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[sv/ptrs_datapath.sv]
// ----------------------------------------------------------------------------
// Power timer register slave datapath
// Holds the register map, the captured bus item and the outgoing byte.
// ----------------------------------------------------------------------------
module ptrs_datapath #(
    parameter int DEFAULT_ADDRESS = ptrs_pkg::DEFAULT_ADDRESS_DEF,
    parameter int FIRMWARE_ID     = ptrs_pkg::FIRMWARE_ID_DEF,
    parameter int BUS_SLEEP_BIT   = ptrs_pkg::BUS_SLEEP_BIT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ptrs_pkg::t_ctrl_cmd    i_cmd,
    input  logic [1:0]             i_item_cmd,
    input  logic [7:0]             i_bus_byte,
    input  logic                   i_last_byte,
    input  logic [7:0]             i_button_a,
    input  logic [7:0]             i_button_b,
    input  logic                   i_charge_pin,
    input  logic [191:0]           i_meas,
    output ptrs_pkg::t_ctrl_status o_status,
    output logic [7:0]             o_read_data,
    output logic                   o_is_read,
    output logic                   o_last_of_run,
    output logic                   o_power_hold,
    output logic                   o_backlight,
    output logic                   o_sleep_request,
    output logic                   o_cycle_mode,
    output logic [6:0]             o_bus_address
);

    localparam logic [2:0] SleepMask   = 3'(3'd1 << BUS_SLEEP_BIT);
    localparam logic [2:0] WakeReset   = ptrs_pkg::SOURCE_MASK & ~SleepMask;
    localparam logic [6:0] AddrReset   = 7'(DEFAULT_ADDRESS);
    localparam logic [7:0] FirmwareId  = 8'(FIRMWARE_ID);

    // Captured item
    logic [1:0]  r_item_cmd;
    logic [7:0]  r_item_byte;
    logic        r_item_last;
    logic [7:0]  r_button_a;
    logic [7:0]  r_button_b;
    logic        r_charge_pin;
    logic [31:0] r_meas [ptrs_pkg::NUM_MEAS_WORDS];

    // Register map
    logic [7:0] r_pointer;
    logic [7:0] r_offset;
    logic       r_power_hold;
    logic       r_backlight;
    logic [2:0] r_wake_src;
    logic [2:0] r_sleep_src;
    logic [1:0] r_src_enable;
    logic [7:0] r_wake_time  [3];
    logic [7:0] r_sleep_time [3];
    logic       r_sleep_request;
    logic       r_cycle_mode;
    logic [7:0] r_boot_select;
    logic [6:0] r_slave_addr;

    // Read run and output register
    logic [7:0] r_index;
    logic [7:0] r_read_data;
    logic       r_is_read;
    logic       r_last_flag;

    ptrs_pkg::t_group group;
    logic [8:0]       wr_addr;
    logic             wr_nz;
    logic [7:0]       meas_off;
    logic [31:0]      meas_word;
    logic [7:0]       meas_byte;
    logic [7:0]       rd_byte;

    assign group   = ptrs_pkg::read_group(r_pointer);
    assign wr_addr = {1'b0, r_pointer} + {1'b0, r_offset};
    assign wr_nz   = (r_item_byte != 8'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item_cmd   <= i_item_cmd;
            r_item_byte  <= i_bus_byte;
            r_item_last  <= i_last_byte;
            r_button_a   <= i_button_a;
            r_button_b   <= i_button_b;
            r_charge_pin <= i_charge_pin;
            for (int w = 0; w < ptrs_pkg::NUM_MEAS_WORDS; w++) begin
                r_meas[w] <= i_meas[w*32 +: 32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer       <= 8'd0;
            r_offset        <= 8'd0;
            r_power_hold    <= 1'b1;
            r_backlight     <= 1'b1;
            r_wake_src      <= WakeReset;
            r_sleep_src     <= ptrs_pkg::SOURCE_MASK;
            r_src_enable    <= 2'b00;
            r_wake_time     <= '{default: 8'd0};
            r_sleep_time    <= '{default: 8'd0};
            r_sleep_request <= 1'b0;
            r_cycle_mode    <= 1'b0;
            r_boot_select   <= 8'd0;
            r_slave_addr    <= AddrReset;
        end else if (i_cmd.apply_pointer) begin
            r_pointer <= r_item_byte;
            r_offset  <= 8'd0;
        end else if (i_cmd.apply_write) begin
            // Each data byte only lands inside the group that the pointer opened.
            if (r_pointer == ptrs_pkg::ADDR_POWER_HOLD) begin
                if (wr_addr == {1'b0, ptrs_pkg::ADDR_POWER_HOLD}) r_power_hold <= wr_nz;
            end else if (r_pointer == ptrs_pkg::ADDR_BACKLIGHT) begin
                if (wr_addr == {1'b0, ptrs_pkg::ADDR_BACKLIGHT}) r_backlight <= wr_nz;
            end else if (r_pointer == ptrs_pkg::ADDR_WAKE_SRC
                         || r_pointer == ptrs_pkg::ADDR_SLEEP_SRC) begin
                if (wr_addr == {1'b0, ptrs_pkg::ADDR_WAKE_SRC}) begin
                    r_wake_src      <= r_item_byte[2:0];
                    r_src_enable[0] <= wr_nz;
                end else if (wr_addr == {1'b0, ptrs_pkg::ADDR_SLEEP_SRC}) begin
                    r_sleep_src     <= r_item_byte[2:0];
                    r_src_enable[1] <= wr_nz;
                end
            end else if (r_pointer >= ptrs_pkg::ADDR_WAKE_TIME
                         && r_pointer <= ptrs_pkg::ADDR_WAKE_END) begin
                if (wr_addr <= {1'b0, ptrs_pkg::ADDR_WAKE_END}) begin
                    r_wake_time[wr_addr[1:0]] <= r_item_byte;
                end
            end else if (r_pointer >= ptrs_pkg::ADDR_SLEEP_TIME
                         && r_pointer <= ptrs_pkg::ADDR_SLEEP_END) begin
                if (wr_addr <= {1'b0, ptrs_pkg::ADDR_SLEEP_END}) begin
                    r_sleep_time[wr_addr[1:0]] <= r_item_byte;
                end
            end else if (r_pointer == ptrs_pkg::ADDR_SLEEP_REQ) begin
                if (wr_addr == {1'b0, ptrs_pkg::ADDR_SLEEP_REQ} && wr_nz
                    && (r_sleep_src & SleepMask) != 3'd0) begin
                    r_sleep_request <= 1'b1;
                end
            end else if (r_pointer == ptrs_pkg::ADDR_CYCLE_MODE) begin
                if (wr_addr == {1'b0, ptrs_pkg::ADDR_CYCLE_MODE}) r_cycle_mode <= wr_nz;
            end else if (r_pointer == ptrs_pkg::ADDR_BOOT_SEL) begin
                if (wr_addr == {1'b0, ptrs_pkg::ADDR_BOOT_SEL}) r_boot_select <= r_item_byte;
            end else if (r_pointer == ptrs_pkg::ADDR_SLAVE_ADDR) begin
                // The address is taken only from a lone data byte below 128.
                if (r_offset == 8'd0 && r_item_last && !r_item_byte[7]) begin
                    r_slave_addr <= r_item_byte[6:0];
                end
            end
            if (r_item_last) begin
                r_offset <= 8'hFF;
            end else if (r_offset != 8'hFF) begin
                r_offset <= r_offset + 8'd1;
            end
        end
    end

    // Measurement bytes, least significant byte of each word first
    assign meas_off = r_index - ptrs_pkg::ADDR_MEAS_LO;

    always_comb begin
        unique case (meas_off[4:2])
            3'd0:    meas_word = r_meas[0];
            3'd1:    meas_word = r_meas[1];
            3'd2:    meas_word = r_meas[2];
            3'd3:    meas_word = r_meas[3];
            3'd4:    meas_word = r_meas[4];
            3'd5:    meas_word = r_meas[5];
            default: meas_word = 32'd0;
        endcase
        meas_byte = meas_word[{meas_off[1:0], 3'b000} +: 8];
    end

    always_comb begin
        rd_byte = 8'd0;
        if (r_index >= ptrs_pkg::ADDR_MEAS_LO && r_index <= ptrs_pkg::ADDR_MEAS_HI) begin
            rd_byte = meas_byte;
        end else if (r_index >= ptrs_pkg::ADDR_WAKE_TIME
                     && r_index <= ptrs_pkg::ADDR_WAKE_END) begin
            rd_byte = r_wake_time[r_index[1:0]];
        end else if (r_index >= ptrs_pkg::ADDR_SLEEP_TIME
                     && r_index <= ptrs_pkg::ADDR_SLEEP_END) begin
            rd_byte = r_sleep_time[r_index[1:0]];
        end else if (r_index == ptrs_pkg::ADDR_POWER_HOLD) begin
            rd_byte = {7'd0, r_power_hold};
        end else if (r_index == ptrs_pkg::ADDR_BACKLIGHT) begin
            rd_byte = {7'd0, r_backlight};
        end else if (r_index == ptrs_pkg::ADDR_BUTTON_A) begin
            rd_byte = r_button_a;
        end else if (r_index == ptrs_pkg::ADDR_BUTTON_B) begin
            rd_byte = r_button_b;
        end else if (r_index == ptrs_pkg::ADDR_WAKE_SRC) begin
            rd_byte = {5'd0, r_wake_src};
        end else if (r_index == ptrs_pkg::ADDR_SLEEP_SRC) begin
            rd_byte = {5'd0, r_sleep_src};
        end else if (r_index == ptrs_pkg::ADDR_CYCLE_MODE) begin
            rd_byte = {7'd0, r_cycle_mode};
        end else if (r_index == ptrs_pkg::ADDR_CHARGING) begin
            rd_byte = {7'd0, !r_charge_pin};
        end else if (r_index == ptrs_pkg::ADDR_FW_ID) begin
            rd_byte = FirmwareId;
        end else if (r_index == ptrs_pkg::ADDR_BOOT_SEL) begin
            rd_byte = r_boot_select;
        end else if (r_index == ptrs_pkg::ADDR_SLAVE_ADDR) begin
            rd_byte = {1'b0, r_slave_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_read) begin
            r_index <= r_pointer;
        end else if (i_cmd.advance) begin
            r_index <= r_index + 8'd1;
        end
        if (i_cmd.apply_write) begin
            r_read_data <= 8'd0;
            r_is_read   <= 1'b0;
            r_last_flag <= 1'b0;
        end else if (i_cmd.load_byte) begin
            r_read_data <= rd_byte;
            r_is_read   <= 1'b1;
            r_last_flag <= (r_index == group.last_addr);
        end
    end

    always_comb begin
        o_status.cmd         = r_item_cmd;
        o_status.read_mapped = group.mapped;
        o_status.run_done    = !r_is_read || r_last_flag;
    end

    // Status bits follow the live registers, which stay still while a result waits.
    assign o_read_data     = r_read_data;
    assign o_is_read       = r_is_read;
    assign o_last_of_run   = r_last_flag;
    assign o_power_hold    = r_power_hold;
    assign o_backlight     = r_backlight;
    assign o_sleep_request = r_sleep_request;
    assign o_cycle_mode    = r_cycle_mode;
    assign o_bus_address   = r_slave_addr;

endmodule

[sv/power_timer_register_slave.sv]
// ----------------------------------------------------------------------------
// Power timer register slave
// Byte-level register map behind a two-wire bus: pointer, writes and read runs.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit up)                        | tuser   | tlast
//  s_axis   | in        | bus_byte, button A, button B, charge pin, | cmd     | last_byte
//           |           | six 32-bit measurement words              |         |
//  m_axis   | out       | read_data, power hold, backlight, sleep   | is_read | last_of_run
//           |           | request, cycle mode, bus address          |         |
//
//  A pointer or ignored item passes through capture and decode only; a write also
//  needs the acknowledgement transfer; a read run adds a load and a send for each
//  byte, set by the single byte output register.
//  Reset is synchronous and active low; it restores the register map defaults.
//  A stalled output holds the block, and no new item is taken until the last
//  result of the current one has been transferred.
// ----------------------------------------------------------------------------
module power_timer_register_slave #(
    parameter int DEFAULT_ADDRESS = ptrs_pkg::DEFAULT_ADDRESS_DEF,
    parameter int FIRMWARE_ID     = ptrs_pkg::FIRMWARE_ID_DEF,
    parameter int BUS_SLEEP_BIT   = ptrs_pkg::BUS_SLEEP_BIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bus_byte[7:0], button_a_status[15:8], button_b_status[23:16], charge_pin[24],
    // input_voltage[56:25], input_current[88:57], port_voltage[120:89],
    // port_current[152:121], battery_voltage[184:153], battery_current[216:185], zero
    input  logic [223:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_data[7:0], power_hold_out[8], backlight_out[9], sleep_request_out[10],
    // cycle_mode_out[11], bus_address_out[18:12], zero[23:19]
    output logic [23:0]  m_axis_tdata,
    // is_read
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    ptrs_pkg::t_ctrl_cmd    cmd;
    ptrs_pkg::t_ctrl_status status;
    logic [7:0]             read_data;
    logic                   power_hold;
    logic                   backlight;
    logic                   sleep_request;
    logic                   cycle_mode;
    logic [6:0]             bus_address;

    ptrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    ptrs_datapath #(
        .DEFAULT_ADDRESS (DEFAULT_ADDRESS),
        .FIRMWARE_ID     (FIRMWARE_ID),
        .BUS_SLEEP_BIT   (BUS_SLEEP_BIT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_item_cmd      (s_axis_tuser),
        .i_bus_byte      (s_axis_tdata[7:0]),
        .i_last_byte     (s_axis_tlast),
        .i_button_a      (s_axis_tdata[15:8]),
        .i_button_b      (s_axis_tdata[23:16]),
        .i_charge_pin    (s_axis_tdata[24]),
        .i_meas          (s_axis_tdata[216:25]),
        .o_status        (status),
        .o_read_data     (read_data),
        .o_is_read       (m_axis_tuser),
        .o_last_of_run   (m_axis_tlast),
        .o_power_hold    (power_hold),
        .o_backlight     (backlight),
        .o_sleep_request (sleep_request),
        .o_cycle_mode    (cycle_mode),
        .o_bus_address   (bus_address)
    );

    assign m_axis_tdata = {5'd0, bus_address, cycle_mode, sleep_request,
                           backlight, power_hold, read_data};

endmodule
